// File: hdl/mac_address_text_parser_macros.svh
// Assertion macros shared by the parser modules.
// Each expects signals named clk and rst_n in the enclosing module.
`ifndef MAC_ADDRESS_TEXT_PARSER_MACROS_SVH
`define MAC_ADDRESS_TEXT_PARSER_MACROS_SVH

`ifndef SYNTH
`define MATP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MATP_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MATP_ASSERT(label, prop, msg)
`define MATP_NEVER(label, expr, msg)
`endif

`endif

// File: hdl/matp_pkg.sv
`timescale 1ns / 1ps

package matp_pkg;

    localparam int MAC_W = 48;
    localparam int TOKEN_DEPTH_DEFAULT = 4;
    localparam int RESULT_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CHAR_TERM  = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic [15:0] BYTE_MAX  = 16'h00FF;
    localparam logic [2:0] GROUPS_BYTE = 3'd6;
    localparam logic [2:0] GROUPS_WORD = 3'd3;

    typedef enum logic [1:0] {
        TOK_DIGIT,
        TOK_SEP,
        TOK_TERM,
        TOK_BAD
    } tok_kind_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_COLON,
        KIND_DASH,
        KIND_DOT
    } sep_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        sep_kind_t   sep;
        logic [3:0]  digit;
    } token_t;

    typedef struct packed {
        logic              ok;
        logic [MAC_W-1:0]  mac;
    } result_t;

endpackage

// File: hdl/matp_fifo.sv
`timescale 1ns / 1ps

`include "mac_address_text_parser_macros.svh"

module matp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `MATP_NEVER(a_count_bound, count_reg > CW'(DEPTH), "queue count beyond depth")

endmodule

// File: hdl/matp_front.sv
`timescale 1ns / 1ps

module matp_front (
    input  logic [7:0]      char_code,
    output matp_pkg::token_t tok
);

    import matp_pkg::*;

    always_comb
    begin
        tok.kind  = TOK_BAD;
        tok.sep   = KIND_NONE;
        tok.digit = 4'h0;
        if (char_code == CHAR_TERM)
        begin
            tok.kind = TOK_TERM;
        end
        else if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            tok.kind  = TOK_DIGIT;
            tok.digit = char_code[3:0];
        end
        else if ((char_code >= 8'h61 && char_code <= 8'h66)
              || (char_code >= 8'h41 && char_code <= 8'h46))
        begin
            // letters a..f and A..F share the low bits 1..6
            tok.kind  = TOK_DIGIT;
            tok.digit = char_code[3:0] + 4'd9;
        end
        else if (char_code == CHAR_COLON)
        begin
            tok.kind = TOK_SEP;
            tok.sep  = KIND_COLON;
        end
        else if (char_code == CHAR_DASH)
        begin
            tok.kind = TOK_SEP;
            tok.sep  = KIND_DASH;
        end
        else if (char_code == CHAR_DOT)
        begin
            tok.kind = TOK_SEP;
            tok.sep  = KIND_DOT;
        end
    end

endmodule

// File: hdl/matp_back.sv
`timescale 1ns / 1ps

`include "mac_address_text_parser_macros.svh"

module matp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  matp_pkg::token_t  tok,
    output logic              tok_pop,
    input  logic              res_full,
    output logic              res_push,
    output matp_pkg::result_t res
);

    import matp_pkg::*;

    logic [15:0]      gv_reg, gv_next;
    logic             ovf_reg, ovf_next;
    sep_kind_t        sep_reg, sep_next;
    logic [2:0]       pos_reg, pos_next;
    logic [MAC_W-1:0] addr_reg, addr_next;
    logic             failed_reg, failed_next;

    sep_kind_t        close_kind;
    logic             close_dot;
    logic             close_fail;
    logic [5:0]       shamt;
    logic [MAC_W-1:0] placed;
    logic [MAC_W-1:0] addr_closed;
    logic [2:0]       pos_inc;
    logic [2:0]       need;
    logic             term_ok;

    assign tok_pop  = tok_valid && (tok.kind != TOK_TERM || !res_full);
    assign res_push = tok_pop && (tok.kind == TOK_TERM);

    // close the current group under the chosen separator
    assign close_kind  = (tok.kind == TOK_TERM) ? sep_reg : tok.sep;
    assign close_dot   = (close_kind == KIND_DOT);
    assign close_fail  = close_dot ? (pos_reg > 3'd2 || ovf_reg)
                                   : (pos_reg > 3'd5 || ovf_reg || gv_reg > BYTE_MAX);
    assign shamt       = close_dot ? {2'd2 - pos_reg[1:0], 4'b0000}
                                   : {3'd5 - pos_reg, 3'b000};
    assign placed      = (close_dot ? {32'b0, gv_reg} : {40'b0, gv_reg[7:0]}) << shamt;
    assign addr_closed = addr_reg | placed;
    assign pos_inc     = pos_reg + 3'd1;
    assign need        = (sep_reg == KIND_DOT) ? GROUPS_WORD : GROUPS_BYTE;
    assign term_ok     = !failed_reg && (sep_reg != KIND_NONE) && !close_fail
                      && (pos_inc == need);

    assign res.ok  = term_ok;
    assign res.mac = term_ok ? addr_closed : '0;

    always_comb
    begin
        gv_next     = gv_reg;
        ovf_next    = ovf_reg;
        sep_next    = sep_reg;
        pos_next    = pos_reg;
        addr_next   = addr_reg;
        failed_next = failed_reg;
        if (tok_pop)
        begin
            case (tok.kind)
                TOK_TERM:
                begin
                    gv_next     = '0;
                    ovf_next    = 1'b0;
                    sep_next    = KIND_NONE;
                    pos_next    = '0;
                    addr_next   = '0;
                    failed_next = 1'b0;
                end
                TOK_DIGIT:
                begin
                    if (!failed_reg)
                    begin
                        ovf_next = ovf_reg || (gv_reg[15:12] != 4'h0);
                        gv_next  = {gv_reg[11:0], tok.digit};
                    end
                end
                TOK_SEP:
                begin
                    if (!failed_reg)
                    begin
                        if (sep_reg == KIND_NONE)
                        begin
                            sep_next = tok.sep;
                        end
                        if (sep_reg != KIND_NONE && sep_reg != tok.sep)
                        begin
                            failed_next = 1'b1;
                        end
                        else if (close_fail)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            addr_next = addr_closed;
                            pos_next  = pos_inc;
                            gv_next   = '0;
                            ovf_next  = 1'b0;
                        end
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg     <= '0;
            ovf_reg    <= 1'b0;
            sep_reg    <= KIND_NONE;
            pos_reg    <= '0;
            addr_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            gv_reg     <= gv_next;
            ovf_reg    <= ovf_next;
            sep_reg    <= sep_next;
            pos_reg    <= pos_next;
            addr_reg   <= addr_next;
            failed_reg <= failed_next;
        end
    end

    `MATP_ASSERT(a_term_clears, (res_push |=> (pos_reg == '0 && sep_reg == KIND_NONE && !failed_reg)), "state not cleared after terminator")
    `MATP_ASSERT(a_fail_zero, ((res_push && !res.ok) |-> (res.mac == '0)), "failed result carries address")
    `MATP_ASSERT(a_fail_sticky, ((failed_reg && !res_push) |=> failed_reg), "error flag dropped mid string")
    `MATP_NEVER(a_pos_bound, pos_reg > GROUPS_BYTE, "group count beyond six")

endmodule

// File: hdl/mac_address_text_parser.sv
`timescale 1ns / 1ps

// Flow: a character pushed into the token queue is decoded by the parser when it reaches
// the head of that queue; the terminator's result is written into the result queue and
// shows on the result side (empty low) once that write is done.
// Throughput: one character per cycle while no terminator waits on a full result queue.
// Reset: rst_n clears both queues and all parser state; no result is waiting.

module mac_address_text_parser #(
    parameter int TOKEN_DEPTH  = matp_pkg::TOKEN_DEPTH_DEFAULT,
    parameter int RESULT_DEPTH = matp_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               char_code,
    output logic                     empty,
    input  logic                     pop,
    output logic                     parse_ok,
    output logic [matp_pkg::MAC_W-1:0] mac_value
);

    import matp_pkg::*;

    token_t                 tok_in;
    logic [$bits(token_t)-1:0] tok_dout;
    token_t                 tok_head;
    logic                   tok_empty;
    logic                   tok_pop;
    logic                   res_full;
    logic                   res_push;
    result_t                res_in;
    logic [$bits(result_t)-1:0] res_dout;
    result_t                res_head;

    matp_front u_front (
        .char_code (char_code),
        .tok       (tok_in)
    );

    matp_fifo #(
        .WIDTH ($bits(token_t)),
        .DEPTH (TOKEN_DEPTH)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (tok_in),
        .full  (full),
        .pop   (tok_pop),
        .dout  (tok_dout),
        .empty (tok_empty)
    );

    assign tok_head = token_t'(tok_dout);

    matp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (!tok_empty),
        .tok       (tok_head),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    matp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign res_head  = result_t'(res_dout);
    assign parse_ok  = res_head.ok;
    assign mac_value = res_head.mac;

endmodule

// File: verif/mac_address_text_parser_checker.sv
`timescale 1ns / 1ps

module mac_address_text_parser_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [7:0]                 char_code,
    input  logic                       empty,
    input  logic                       pop,
    input  logic                       parse_ok,
    input  logic [matp_pkg::MAC_W-1:0] mac_value,
    output int                         fail_count,
    output int                         pending
);
    import matp_pkg::*;

    logic [15:0]      grp_val = '0;
    logic             grp_ovf = 1'b0;
    sep_kind_t        sep_kind = KIND_NONE;
    logic [2:0]       grp_pos = '0;
    logic [MAC_W-1:0] addr = '0;
    logic             failed = 1'b0;
    result_t          mac_expect_q[$];
    int               fail_total = 0;
    int               open_count = 0;

    assign fail_count = fail_total;
    assign pending = open_count;

    task automatic report_mismatch(input string what, input logic [MAC_W-1:0] got,
                                   input logic [MAC_W-1:0] want);
        $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
        fail_total++;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    task automatic clear_parse();
        grp_val = '0;
        grp_ovf = 1'b0;
        sep_kind = KIND_NONE;
        grp_pos = '0;
        addr = '0;
        failed = 1'b0;
    endtask

    // Close the open group into the address; ok stays low on a rejected group.
    task automatic close_group(input sep_kind_t kind, output logic ok);
        int               shift;
        logic [MAC_W-1:0] part;
        ok = 1'b0;
        if (kind == KIND_DOT)
        begin
            if (grp_pos <= 3'd2 && !grp_ovf)
            begin
                shift = 16 * (2 - int'(grp_pos));
                part = {32'd0, grp_val};
                addr = addr | (part << shift);
                ok = 1'b1;
            end
        end
        else if (grp_pos <= 3'd5 && !grp_ovf && grp_val <= BYTE_MAX)
        begin
            shift = 8 * (5 - int'(grp_pos));
            part = {40'd0, grp_val[7:0]};
            addr = addr | (part << shift);
            ok = 1'b1;
        end
        if (ok)
        begin
            grp_pos = grp_pos + 3'd1;
            grp_val = '0;
            grp_ovf = 1'b0;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        int        d;
        logic      ok;
        sep_kind_t kind;
        result_t   res;
        if (c == CHAR_TERM)
        begin
            ok = !failed && sep_kind != KIND_NONE;
            if (ok)
            begin
                close_group(sep_kind, ok);
            end
            if (ok)
            begin
                ok = grp_pos == ((sep_kind == KIND_DOT) ? GROUPS_WORD : GROUPS_BYTE);
            end
            res.ok = ok;
            res.mac = ok ? addr : '0;
            mac_expect_q.push_back(res);
            clear_parse();
        end
        else if (!failed)
        begin
            d = hex_nibble(c);
            if (d >= 0)
            begin
                if (grp_val[15:12] != 4'd0)
                begin
                    grp_ovf = 1'b1;
                end
                grp_val = {grp_val[11:0], 4'(d)};
            end
            else
            begin
                case (c)
                    CHAR_COLON: kind = KIND_COLON;
                    CHAR_DASH:  kind = KIND_DASH;
                    CHAR_DOT:   kind = KIND_DOT;
                    default:    kind = KIND_NONE;
                endcase
                if (kind == KIND_NONE)
                begin
                    failed = 1'b1;
                end
                else if (sep_kind != KIND_NONE && sep_kind != kind)
                begin
                    failed = 1'b1;
                end
                else
                begin
                    if (sep_kind == KIND_NONE)
                    begin
                        sep_kind = kind;
                    end
                    close_group(kind, ok);
                    if (!ok)
                    begin
                        failed = 1'b1;
                    end
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (mac_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected word", mac_value, '0);
                end
                else
                begin
                    if (parse_ok !== mac_expect_q[0].ok)
                    begin
                        report_mismatch("parse_ok", MAC_W'(parse_ok),
                                        MAC_W'(mac_expect_q[0].ok));
                    end
                    if (mac_value !== mac_expect_q[0].mac)
                    begin
                        report_mismatch("mac_value", mac_value, mac_expect_q[0].mac);
                    end
                    void'(mac_expect_q.pop_front());
                end
            end
            if (push && !full)
            begin
                parse_char(char_code);
            end
            open_count <= mac_expect_q.size();
        end
    end

endmodule

// File: verif/mac_address_text_parser_tb.sv
`timescale 1ns / 1ps

module mac_address_text_parser_tb;
    import matp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int STALL_CYCLES = 300;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             pop = 1'b0;
    logic [7:0]       char_code = '0;
    logic             full;
    logic             empty;
    logic             parse_ok;
    logic [MAC_W-1:0] mac_value;
    int               fail_count;
    int               pending;

    bit               quiet = 1'b0;
    bit               stall_req = 1'b0;
    bit               stall_done = 1'b0;
    int               hold_left = 0;
    int               cycle_count = 0;
    int               sent_count = 0;
    logic [7:0]       text_q[$];

    mac_address_text_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .empty     (empty),
        .pop       (pop),
        .parse_ok  (parse_ok),
        .mac_value (mac_value)
    );

    mac_address_text_parser_checker mac_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .char_code  (char_code),
        .empty      (empty),
        .pop        (pop),
        .parse_ok   (parse_ok),
        .mac_value  (mac_value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("mac_address_text_parser: mismatch");
            $finish;
        end
    end

    // Result side: random pops, with one long hold-off on request.
    always @(posedge clk)
    begin
        if (stall_req && !stall_done)
        begin
            hold_left = STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
        begin
            pop <= quiet || ($urandom_range(0, 99) >= 28);
        end
    end

    task automatic send_char(input logic [7:0] c);
        while (!quiet && $urandom_range(0, 99) < 28)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
        begin
            send_char(text_q[i]);
        end
        send_char(CHAR_TERM);
        text_q.delete();
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_q.push_back(s[i]);
        end
    endtask

    // Hold the input until every expected word has come back.
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'("0") + 8'(n);
        end
        return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    task automatic add_group(input int ndig, input bit lead_zero);
        for (int i = 0; i < ndig; i++)
        begin
            if (i == 0 && lead_zero)
            begin
                text_q.push_back("0");
            end
            else
            begin
                text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end
        end
    endtask

    task automatic build_byte_form(input logic [7:0] sep);
        int r;
        for (int g = 0; g < 6; g++)
        begin
            if (g > 0)
            begin
                text_q.push_back(sep);
            end
            r = $urandom_range(0, 19);
            if (r < 16)
                add_group(2, 1'b0);
            else if (r == 16)
                add_group(0, 1'b0);
            else if (r == 17)
                add_group(1, 1'b0);
            else
                add_group(3, r == 18);
        end
    endtask

    task automatic build_word_form();
        int r;
        for (int g = 0; g < 3; g++)
        begin
            if (g > 0)
            begin
                text_q.push_back(CHAR_DOT);
            end
            r = $urandom_range(0, 19);
            if (r < 16)
                add_group(4, 1'b0);
            else if (r == 16)
                add_group(0, 1'b0);
            else if (r == 17)
                add_group($urandom_range(1, 3), 1'b0);
            else
                add_group(5, r == 18);
        end
    endtask

    function automatic logic [7:0] any_sep();
        case ($urandom_range(0, 2))
            0:       return CHAR_COLON;
            1:       return CHAR_DASH;
            default: return CHAR_DOT;
        endcase
    endfunction

    task automatic break_text();
        int pos;
        pos = (text_q.size() > 0) ? $urandom_range(0, text_q.size() - 1) : 0;
        case ($urandom_range(0, 3))
            0:
            begin
                if (text_q.size() > 0)
                    text_q[pos] = 8'($urandom_range(1, 255));
            end
            1: text_q.insert(pos, any_sep());
            2:
            begin
                if (text_q.size() > 0)
                    text_q.delete(pos);
            end
            default:
            begin
                text_q.push_back(any_sep());
                add_group($urandom_range(0, 4), 1'b0);
            end
        endcase
    endtask

    task automatic random_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            build_byte_form($urandom_range(0, 1) ? CHAR_COLON : CHAR_DASH);
        end
        else if (r < 70)
        begin
            build_word_form();
        end
        else if (r < 90)
        begin
            if ($urandom_range(0, 1))
                build_word_form();
            else
                build_byte_form(any_sep());
            break_text();
        end
        else
        begin
            repeat ($urandom_range(0, 20))
                text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic random_phase(input int n);
        int target;
        target = sent_count + n;
        while (sent_count < target)
        begin
            random_text();
            send_text();
        end
    endtask

    initial
    begin
        string directed[] = '{"", ":::::", "..", "-----", ":-", "100:", "12345.", "g:",
                              "::::::", "...", "FF:ff:0:9:a:F", "0ff-1-2-3-4-5",
                              "ffff.FFFF.0ffff", "12:34.56"};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            load_text(directed[i]);
            send_text();
        end
        text_q.push_back(8'hFF);
        send_text();
        drain();

        random_phase(600);
        drain();

        quiet = 1'b1;
        random_phase(400);
        drain();
        quiet = 1'b0;

        // Fill the block while the result side holds off.
        stall_req = 1'b1;
        random_phase(200);
        drain();

        random_phase(400);
        drain();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("mac_address_text_parser: match");
        end
        else
        begin
            $display("mac_address_text_parser: mismatch");
        end
        $finish;
    end

endmodule
